// ===== hdl/ttip_pkg.sv =====
// Package for the text-to-integer parser: phase codes, register indexes, constants, digit decode.
package ttip_pkg;

  localparam int VALUE_BITS_DEFAULT = 64;
  localparam int COUNT_BITS_DEFAULT = 16;

  localparam int BASE_BITS     = 6;
  localparam int CHAR_BITS     = 8;
  localparam int CONSUMED_BITS = 16;
  localparam int MODE_BITS     = 2;
  localparam int CFG_DATA_BITS = 6;

  localparam logic [BASE_BITS-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_BITS-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_BITS-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_HEX   = 6'd16;

  localparam logic [MODE_BITS-1:0] MODE_SIGNED = 2'd0;

  // Register indexes on the configuration port.
  localparam logic REG_NUMBER_BASE = 1'b0;
  localparam logic REG_SIGN_MODE   = 1'b1;

  localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_BITS-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_BITS-1:0] CH_LZ    = 8'h7A;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_PREFIX,
    PH_ZERO_AUTO,
    PH_ZERO_HEX,
    PH_DIGITS,
    PH_STOPPED
  } phase_t;

  typedef struct packed {
    logic                 ok;
    logic [BASE_BITS-1:0] val;
  } digit_t;

  function automatic digit_t digit_value(input logic [CHAR_BITS-1:0] c);
    digit_t d;
    logic [CHAR_BITS-1:0] diff;
    d    = '0;
    diff = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      diff  = c - CH_ZERO;
      d.ok  = 1'b1;
      d.val = diff[BASE_BITS-1:0];
    end else if (c >= CH_LA && c <= CH_LZ) begin
      diff  = c - CH_LA + 8'd10;
      d.ok  = 1'b1;
      d.val = diff[BASE_BITS-1:0];
    end else if (c >= CH_UA && c <= CH_UZ) begin
      diff  = c - CH_UA + 8'd10;
      d.ok  = 1'b1;
      d.val = diff[BASE_BITS-1:0];
    end
    return d;
  endfunction

endpackage

// ===== hdl/text_to_integer_parser.sv =====
// Streaming text-to-integer parser: input register, phase/accumulator update, result register.
// A word is held in the input register and folded into the parser state from there; the result
// of a zero byte is loaded into the result register when that byte is folded in.
// The parser takes one word per cycle while no zero byte stalls; its state update holds one
// VALUE_BITS by 6 bit multiply-add. Ending zero bytes stall only while a result is not taken.
// Reset (synchronous, rst high) clears both handshake stages, rearms the parser and loads
// number_base = 10 and sign_mode = 0.
module text_to_integer_parser #(
  parameter int VALUE_BITS = ttip_pkg::VALUE_BITS_DEFAULT,
  parameter int COUNT_BITS = ttip_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration write port.
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [ttip_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  // Character input channel.
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [ttip_pkg::CHAR_BITS-1:0]        char_code,
  // Result output channel.
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [VALUE_BITS-1:0]                 value,
  output logic [ttip_pkg::CONSUMED_BITS-1:0]    consumed
);

  // Configuration registers.
  logic [ttip_pkg::BASE_BITS-1:0] number_base;
  logic [ttip_pkg::MODE_BITS-1:0] sign_mode;

  // Input register.
  logic                           in_full;
  logic [ttip_pkg::CHAR_BITS-1:0] in_char;

  // Parser state and its next values.
  ttip_pkg::phase_t               phase, phase_next;
  logic [ttip_pkg::BASE_BITS-1:0] active_base, active_base_next;
  logic [VALUE_BITS-1:0]          accumulator, accumulator_next;
  logic                           negative_flag, negative_flag_next;
  logic [COUNT_BITS-1:0]          position, position_next;
  logic [COUNT_BITS-1:0]          stop_position, stop_position_next;

  logic                           is_end;
  logic                           process;
  logic [VALUE_BITS-1:0]          result_value;
  logic [COUNT_BITS-1:0]          result_count;
  ttip_pkg::digit_t               dig;

  // Saturating add of one or two consumed bytes to the position counter.
  function automatic logic [COUNT_BITS-1:0] sat_bump(input logic [COUNT_BITS-1:0] p,
                                                     input logic [1:0] n);
    logic [COUNT_BITS:0] sum;
    sum = {1'b0, p} + {{(COUNT_BITS-1){1'b0}}, n};
    return sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
  endfunction

  // The held word is folded in whenever it is not a zero byte, or when the result register
  // can take the finished number in this cycle.
  assign is_end   = (in_char == ttip_pkg::CH_NUL);
  assign process  = in_full && (!is_end || !out_valid || out_ready);
  assign in_ready = !in_full || process;
  assign dig      = ttip_pkg::digit_value(in_char);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= ttip_pkg::BASE_RESET;
      sign_mode   <= ttip_pkg::MODE_SIGNED;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ttip_pkg::REG_NUMBER_BASE: number_base <= cfg_data[ttip_pkg::BASE_BITS-1:0];
        ttip_pkg::REG_SIGN_MODE:   sign_mode   <= cfg_data[ttip_pkg::MODE_BITS-1:0];
        default:                   ;
      endcase
    end
  end

  // Input register: accepts a new word while empty or while the held one is being folded in.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (process) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char <= char_code;
    end
  end

  // One character can walk through several phases in the same cycle: leading characters
  // that are not whitespace or a sign fall into the prefix check, and a prefix that is not
  // taken falls into the digit check. The checks run in phase order, so each one only has
  // to look at the phase left behind by the check above it.
  always_comb begin
    ttip_pkg::phase_t ph;
    logic             cont;
    phase_next         = phase;
    active_base_next   = active_base;
    accumulator_next   = accumulator;
    negative_flag_next = negative_flag;
    position_next      = position;
    stop_position_next = stop_position;
    ph                 = phase;
    cont               = 1'b1;

    if (is_end) begin
      // The string is over: rearm for the next one.
      phase_next         = ttip_pkg::PH_SPACE;
      active_base_next   = '0;
      accumulator_next   = '0;
      negative_flag_next = 1'b0;
      position_next      = '0;
      stop_position_next = '0;
    end else begin
      if (ph == ttip_pkg::PH_SPACE) begin
        if (in_char == ttip_pkg::CH_SPACE ||
            (in_char >= ttip_pkg::CH_TAB && in_char <= ttip_pkg::CH_CR)) begin
          position_next = sat_bump(position_next, 2'd1);
          cont          = 1'b0;
        end else if (in_char == ttip_pkg::CH_MINUS) begin
          if (sign_mode[1]) begin
            // Unsigned with minus rejected: the minus stops parsing and is not counted.
            stop_position_next = position_next;
            phase_next         = ttip_pkg::PH_STOPPED;
          end else begin
            negative_flag_next = (sign_mode == ttip_pkg::MODE_SIGNED);
            position_next      = sat_bump(position_next, 2'd1);
            phase_next         = ttip_pkg::PH_PREFIX;
          end
          cont = 1'b0;
        end else if (in_char == ttip_pkg::CH_PLUS) begin
          position_next = sat_bump(position_next, 2'd1);
          phase_next    = ttip_pkg::PH_PREFIX;
          cont          = 1'b0;
        end else begin
          ph = ttip_pkg::PH_PREFIX;
        end
      end

      if (cont && ph == ttip_pkg::PH_PREFIX) begin
        if (number_base == ttip_pkg::BASE_AUTO) begin
          if (in_char == ttip_pkg::CH_ZERO) begin
            position_next = sat_bump(position_next, 2'd1);
            phase_next    = ttip_pkg::PH_ZERO_AUTO;
            cont          = 1'b0;
          end else begin
            active_base_next = ttip_pkg::BASE_DEC;
            ph               = ttip_pkg::PH_DIGITS;
          end
        end else begin
          active_base_next = number_base;
          if (number_base == ttip_pkg::BASE_HEX && in_char == ttip_pkg::CH_ZERO) begin
            // Held back: either the start of a 0x prefix or a lone zero digit.
            phase_next = ttip_pkg::PH_ZERO_HEX;
            cont       = 1'b0;
          end else begin
            ph = ttip_pkg::PH_DIGITS;
          end
        end
      end

      if (cont && ph == ttip_pkg::PH_ZERO_AUTO) begin
        if (in_char == ttip_pkg::CH_LX || in_char == ttip_pkg::CH_UX) begin
          active_base_next = ttip_pkg::BASE_HEX;
          position_next    = sat_bump(position_next, 2'd1);
          phase_next       = ttip_pkg::PH_DIGITS;
          cont             = 1'b0;
        end else begin
          active_base_next = ttip_pkg::BASE_OCT;
          ph               = ttip_pkg::PH_DIGITS;
        end
      end

      if (cont && ph == ttip_pkg::PH_ZERO_HEX) begin
        if (in_char == ttip_pkg::CH_LX || in_char == ttip_pkg::CH_UX) begin
          position_next = sat_bump(position_next, 2'd2);
          phase_next    = ttip_pkg::PH_DIGITS;
          cont          = 1'b0;
        end else begin
          // The held zero was a digit; it adds nothing to the value.
          position_next = sat_bump(position_next, 2'd1);
          ph            = ttip_pkg::PH_DIGITS;
        end
      end

      if (cont && ph == ttip_pkg::PH_DIGITS) begin
        if (dig.ok && dig.val < active_base_next) begin
          accumulator_next = VALUE_BITS'(accumulator * VALUE_BITS'(active_base_next)) +
                             VALUE_BITS'(dig.val);
          position_next    = sat_bump(position_next, 2'd1);
          phase_next       = ttip_pkg::PH_DIGITS;
        end else begin
          stop_position_next = position_next;
          phase_next         = ttip_pkg::PH_STOPPED;
        end
      end
    end
  end

  // Finished number for a zero byte. A zero still held back in base 16 counts as consumed.
  always_comb begin
    result_value = negative_flag ? (VALUE_BITS'(0) - accumulator) : accumulator;
    if (phase == ttip_pkg::PH_STOPPED) begin
      result_count = stop_position;
    end else if (phase == ttip_pkg::PH_ZERO_HEX) begin
      result_count = sat_bump(position, 2'd1);
    end else begin
      result_count = position;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ttip_pkg::PH_SPACE;
      active_base   <= '0;
      accumulator   <= '0;
      negative_flag <= 1'b0;
      position      <= '0;
      stop_position <= '0;
    end else if (process) begin
      phase         <= phase_next;
      active_base   <= active_base_next;
      accumulator   <= accumulator_next;
      negative_flag <= negative_flag_next;
      position      <= position_next;
      stop_position <= stop_position_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process && is_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process && is_end) begin
      value    <= result_value;
      consumed <= ttip_pkg::CONSUMED_BITS'(result_count);
    end
  end

  // A zero byte always rearms the parser.
  a_rearm: assert property (@(posedge clk) disable iff (rst)
    (process && is_end) |=> (phase == ttip_pkg::PH_SPACE && position == '0 && !negative_flag))
    else $error("parser did not rearm after the end of a string");

  // A result word appears only because a zero byte was folded in.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(process && is_end))
    else $error("result word without a zero byte");

  // Once parsing stops, later characters of the string leave the state alone.
  a_stopped_holds: assert property (@(posedge clk) disable iff (rst)
    (process && !is_end && phase == ttip_pkg::PH_STOPPED) |=>
      (phase == ttip_pkg::PH_STOPPED && $stable(stop_position) && $stable(accumulator)))
    else $error("stopped parser changed state");

  // The consumed-byte counter saturates instead of wrapping.
  a_count_saturates: assert property (@(posedge clk) disable iff (rst)
    (process && !is_end && position == '1) |=> (position == '1))
    else $error("position counter wrapped");

endmodule
